@@ design/bovm_pkg.sv @@
// Package with the shared types and codes of the byte operand machine.
`timescale 1ns / 1ps

package bovm_pkg;

  // Memory geometry
  localparam int MEM_ADDR_BITS = 16;

  typedef logic [MEM_ADDR_BITS-1:0] addr_t;
  typedef logic [1:0]               status_t;
  typedef logic [4:0]               opcode_t;

  // Result status codes
  localparam status_t ST_STEP = 2'd0;
  localparam status_t ST_OUT  = 2'd1;
  localparam status_t ST_HALT = 2'd2;
  localparam status_t ST_LOAD = 2'd3;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Opcodes
  localparam opcode_t OP_JMP  = 5'd0;
  localparam opcode_t OP_ADD  = 5'd1;
  localparam opcode_t OP_SUB  = 5'd2;
  localparam opcode_t OP_MUL  = 5'd3;
  localparam opcode_t OP_DIV  = 5'd4;
  localparam opcode_t OP_AND  = 5'd5;
  localparam opcode_t OP_OR   = 5'd6;
  localparam opcode_t OP_XOR  = 5'd7;
  localparam opcode_t OP_OUT  = 5'd8;
  localparam opcode_t OP_BRZ  = 5'd30;
  localparam opcode_t OP_COPY = 5'd31;

  // Fixed values
  localparam logic [26:0] WORD_ADDR_MASK = 27'h7ffffff;
  localparam logic [7:0]  DIV_ZERO_RES   = 8'hff;

endpackage

@@ design/bovm_in_if.sv @@
// Input channel interface: mode, load address and load byte of one item.
`timescale 1ns / 1ps

interface bovm_in_if;
  import bovm_pkg::*;

  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] load_addr;
  logic [7:0]  load_data;

  modport source (output valid, mode, load_addr, load_data, input ready);
  modport sink   (input valid, mode, load_addr, load_data, output ready);
endinterface

@@ design/bovm_out_if.sv @@
// Result channel interface: status, emitted byte and program counter of one item.
`timescale 1ns / 1ps

interface bovm_out_if;
  import bovm_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  out_byte;
  logic [15:0] next_pc;

  modport source (output valid, status, out_byte, next_pc, input ready);
  modport sink   (input valid, status, out_byte, next_pc, output ready);
endinterface

@@ design/byte_operand_vm_core.sv @@
// Byte operand machine: shared code/data memory, fetch/execute sequencer and result register.
`timescale 1ns / 1ps
//
// Usage: each item on in_if either loads one program byte (mode 0) or executes
// one instruction at the program counter (mode 1). Every item gives exactly one
// item on out_if with a status, the emitted byte (zero unless status is 1) and
// the program counter after the item.
// Items are taken one at a time; in_if.ready is high only while the sequencer
// is idle. All memory traffic goes through one byte-wide port, one byte per
// cycle. A load or a halted step goes straight to the response; an ordinary
// step makes four byte fetches, executes and responds; a divide with B not
// zero also runs a restoring divider before it writes the quotient; a word
// copy makes three word fetches and four writes.
// The result register lets the next item be accepted while a result still waits;
// if the receiver stalls, the sequencer holds its finished item until the
// register is free.
// Reset clears the program counter, the halt flag and the handshake state;
// the memory is not cleared and is defined only where it has been written.
module byte_operand_vm_core (
  input  logic          clk,
  input  logic          rst_n,
  bovm_in_if.sink       in_if,
  bovm_out_if.source    out_if
);
  import bovm_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_CPWR = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  // Word read phases
  localparam logic [1:0] PH_INSN = 2'd0;
  localparam logic [1:0] PH_DST  = 2'd1;
  localparam logic [1:0] PH_SRC  = 2'd2;

  // Byte-wide ALU for the two-operand opcodes other than divide.
  function automatic logic [7:0] alu_f(input opcode_t op, input logic [7:0] a,
                                       input logic [7:0] b);
    logic [15:0] prod;
    logic [7:0]  res;
    prod = 16'(a) * 16'(b);
    case (op)
      OP_ADD:  res = a + b;
      OP_SUB:  res = a - b;
      OP_MUL:  res = prod[7:0];
      OP_AND:  res = a & b;
      OP_OR:   res = a | b;
      default: res = a ^ b;
    endcase
    return res;
  endfunction

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  addr_t       pc_r, pc_nxt;
  logic        halted_r, halted_nxt;
  addr_t       base_r, base_nxt;
  addr_t       dst_r, dst_nxt;
  logic [31:0] w_r, w_nxt;
  logic [31:0] x_r, x_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  quo_r, quo_nxt;
  status_t     st_r, st_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_pc_r;
  logic        out_load;

  // Memory port
  logic [7:0]  mem_r [2**MEM_ADDR_BITS];
  logic [7:0]  rd_data_r;
  addr_t       mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wdata;

  // Decoded instruction fields
  opcode_t     op;
  logic [7:0]  opa;
  logic [7:0]  opb;
  logic [2:0]  offs;
  addr_t       jmp_tgt;
  logic [31:0] shifted;
  logic [8:0]  trial;
  logic        in_acc;

  assign op      = w_r[31:27];
  assign offs    = w_r[26:24];
  assign opa     = w_r[23:16];
  assign opb     = w_r[15:8];
  assign jmp_tgt = addr_t'({w_r[26:0] & WORD_ADDR_MASK, 2'b00});

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  // Word being assembled from the byte returned by the memory
  assign shifted = (phase_r == PH_INSN) ? {w_r[23:0], rd_data_r} : {x_r[23:0], rd_data_r};
  // One step of the restoring divider
  assign trial   = {rem_r, quo_r[7]} - {1'b0, opb};

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    pc_nxt     = pc_r;
    halted_nxt = halted_r;
    base_nxt   = base_r;
    dst_nxt    = dst_r;
    w_nxt      = w_r;
    x_nxt      = x_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    st_nxt     = st_r;
    ob_nxt     = ob_r;
    mem_addr   = pc_r;
    mem_we     = 1'b0;
    mem_wdata  = x_r[31:24];
    out_load   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // The first instruction byte is requested here, ahead of acceptance.
        if (in_acc) begin
          ob_nxt = 8'h00;
          if (in_if.mode == MODE_LOAD) begin
            mem_we    = 1'b1;
            mem_addr  = addr_t'(in_if.load_addr);
            mem_wdata = in_if.load_data;
            st_nxt    = ST_LOAD;
            state_nxt = S_RESP;
          end else if (halted_r) begin
            st_nxt    = ST_HALT;
            state_nxt = S_RESP;
          end else begin
            st_nxt    = ST_STEP;
            base_nxt  = pc_r;
            phase_nxt = PH_INSN;
            cnt_nxt   = 3'd1;
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        // Request byte cnt, collect byte cnt-1.
        mem_addr = base_r + addr_t'(cnt_r);
        if (cnt_r != 3'd0) begin
          if (phase_r == PH_INSN) begin
            w_nxt = shifted;
          end else begin
            x_nxt = shifted;
          end
        end
        if (cnt_r == 3'd4) begin
          cnt_nxt = 3'd0;
          unique case (phase_r)
            PH_INSN: state_nxt = S_EXEC;
            PH_DST: begin
              dst_nxt   = addr_t'({shifted[26:0] & WORD_ADDR_MASK, 2'b00});
              base_nxt  = jmp_tgt;
              phase_nxt = PH_SRC;
            end
            default: state_nxt = S_CPWR;
          endcase
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end

      S_EXEC: begin
        pc_nxt    = pc_r + addr_t'(4);
        state_nxt = S_RESP;
        mem_addr  = pc_r + addr_t'(offs);
        unique case (op) inside
          OP_JMP: begin
            if (jmp_tgt == pc_r) begin
              halted_nxt = 1'b1;
              st_nxt     = ST_HALT;
              pc_nxt     = pc_r;
            end else begin
              pc_nxt = jmp_tgt;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: begin
            mem_we    = 1'b1;
            mem_wdata = alu_f(op, opa, opb);
          end
          OP_DIV: begin
            if (opb == 8'h00) begin
              mem_we    = 1'b1;
              mem_wdata = DIV_ZERO_RES;
            end else begin
              pc_nxt    = pc_r;
              rem_nxt   = 8'h00;
              quo_nxt   = opa;
              cnt_nxt   = 3'd0;
              state_nxt = S_DIV;
            end
          end
          OP_OUT: begin
            st_nxt = ST_OUT;
            ob_nxt = opa;
          end
          OP_BRZ: begin
            if (opa == 8'h00) begin
              if (opb == 8'h00) begin
                halted_nxt = 1'b1;
                st_nxt     = ST_HALT;
                pc_nxt     = pc_r;
              end else begin
                pc_nxt = pc_r + addr_t'({opb, 2'b00});
              end
            end
          end
          OP_COPY: begin
            pc_nxt    = pc_r;
            base_nxt  = pc_r + addr_t'(4);
            phase_nxt = PH_DST;
            cnt_nxt   = 3'd0;
            state_nxt = S_RD;
          end
          default: ;
        endcase
      end

      S_DIV: begin
        // One quotient bit per cycle, most significant first.
        if (!trial[8]) begin
          rem_nxt = trial[7:0];
          quo_nxt = {quo_r[6:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[6:0], quo_r[7]};
          quo_nxt = {quo_r[6:0], 1'b0};
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = S_WB;
        end
      end

      S_WB: begin
        mem_we    = 1'b1;
        mem_addr  = pc_r + addr_t'(offs);
        mem_wdata = quo_r;
        pc_nxt    = pc_r + addr_t'(4);
        state_nxt = S_RESP;
      end

      S_CPWR: begin
        // Source word leaves x_r a byte at a time, highest byte first.
        mem_we    = 1'b1;
        mem_addr  = dst_r + addr_t'(cnt_r);
        mem_wdata = x_r[31:24];
        x_nxt     = {x_r[23:0], 8'h00};
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          pc_nxt    = pc_r + addr_t'(8);
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_INSN;
      cnt_r       <= 3'd0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      pc_r        <= pc_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    dst_r  <= dst_nxt;
    w_r    <= w_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    st_r   <= st_nxt;
    ob_r   <= ob_nxt;
    if (out_load) begin
      out_status_r <= st_r;
      out_byte_r   <= ob_r;
      out_pc_r     <= 16'(pc_r);
    end
  end

  // Code and data memory, one byte port with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem_r[mem_addr];
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_status_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.next_pc  = out_pc_r;

  // Halt is sticky.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared");

  // A halted result is only ever reported once the machine has halted.
  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_HALT) |-> halted_r)
    else $error("halted status without halt flag");

  // While idle, memory is written only by an accepted load item.
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_IDLE) |-> (in_acc && in_if.mode == MODE_LOAD))
    else $error("memory write while idle without a load item");

  // Loading the result register makes a result valid and returns the sequencer to idle.
  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result register not loaded on completion");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the byte operand machine: directed table, random programs, halt.
`timescale 1ns / 1ps

module tb_top;
  import bovm_pkg::*;

  localparam int MEM_BYTES      = 1 << MEM_ADDR_BITS;
  localparam int ITEM_TOTAL     = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 25;
  localparam int MAX_GAP        = 12;
  localparam bit TYPED          = 1'b1;
  localparam bit PREDICTED      = 1'b0;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic [15:0] next_pc;
  } vm_result_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        fixed;
    status_t     status;
    logic [7:0]  out_byte;
    logic [15:0] next_pc;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bovm_in_if  in_if ();
  bovm_out_if out_if ();

  byte_operand_vm_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Shadow copy of the machine state.
  logic [7:0] vm_mem [MEM_BYTES];
  bit         vm_written [MEM_BYTES];
  addr_t      vm_pc;
  bit         vm_halted;

  vm_result_t awaited_results [$];
  int         item_count;
  int         mismatch_count;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         quiet_cycles;
  addr_t      region_base;

  // Directed program: divide by zero into the instruction itself, output, a jump to the
  // top of memory and a word copy whose destination word fetch and destination wrap round to address 0.
  stim_row_t directed_rows [23] = '{
    '{MODE_LOAD, 16'h0000, 8'h20, TYPED,     ST_LOAD, 8'h00, 16'h0000},
    '{MODE_LOAD, 16'h0001, 8'hff, TYPED,     ST_LOAD, 8'h00, 16'h0000},
    '{MODE_LOAD, 16'h0002, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'h0000},
    '{MODE_LOAD, 16'h0003, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'h0000},
    '{MODE_STEP, 16'hffff, 8'hff, TYPED,     ST_STEP, 8'h00, 16'h0004},
    '{MODE_LOAD, 16'h0004, 8'h40, TYPED,     ST_LOAD, 8'h00, 16'h0004},
    '{MODE_LOAD, 16'h0005, 8'ha5, TYPED,     ST_LOAD, 8'h00, 16'h0004},
    '{MODE_LOAD, 16'h0006, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'h0004},
    '{MODE_LOAD, 16'h0007, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'h0004},
    '{MODE_STEP, 16'h0000, 8'h00, TYPED,     ST_OUT,  8'ha5, 16'h0008},
    '{MODE_LOAD, 16'h0008, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'h0008},
    '{MODE_LOAD, 16'h0009, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'h0008},
    '{MODE_LOAD, 16'h000a, 8'h3f, TYPED,     ST_LOAD, 8'h00, 16'h0008},
    '{MODE_LOAD, 16'h000b, 8'hff, TYPED,     ST_LOAD, 8'h00, 16'h0008},
    '{MODE_STEP, 16'h5a5a, 8'h5a, PREDICTED, ST_STEP, 8'h00, 16'h0000},
    '{MODE_LOAD, 16'hfffc, 8'hf8, TYPED,     ST_LOAD, 8'h00, 16'hfffc},
    '{MODE_LOAD, 16'hfffd, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'hfffc},
    '{MODE_LOAD, 16'hfffe, 8'h00, TYPED,     ST_LOAD, 8'h00, 16'hfffc},
    '{MODE_LOAD, 16'hffff, 8'h01, TYPED,     ST_LOAD, 8'h00, 16'hfffc},
    '{MODE_STEP, 16'ha5a5, 8'ha5, PREDICTED, ST_STEP, 8'h00, 16'h0000},
    '{MODE_STEP, 16'h0000, 8'h00, PREDICTED, ST_STEP, 8'h00, 16'h0000},
    '{MODE_STEP, 16'h0000, 8'h00, PREDICTED, ST_STEP, 8'h00, 16'h0000},
    '{MODE_STEP, 16'h0000, 8'h00, PREDICTED, ST_STEP, 8'h00, 16'h0000}
  };

  // Clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Memory access of the shadow state; every address wraps with the width of addr_t.
  function automatic void mem_store(addr_t a, logic [7:0] v);
    vm_mem[a]     = v;
    vm_written[a] = 1'b1;
  endfunction

  function automatic logic [31:0] peek_word(addr_t a);
    return {vm_mem[a], vm_mem[addr_t'(a + 16'd1)], vm_mem[addr_t'(a + 16'd2)],
            vm_mem[addr_t'(a + 16'd3)]};
  endfunction

  function automatic bit word_defined(addr_t a);
    bit ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) ok &= vm_written[addr_t'(a + i)];
    return ok;
  endfunction

  // Word field times four, cut to the memory size.
  function automatic addr_t word_target(logic [31:0] w);
    return addr_t'({w[26:0] & WORD_ADDR_MASK, 2'b00});
  endfunction

  function automatic logic [7:0] alu_result(opcode_t op, logic [7:0] a, logic [7:0] b);
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: return (b == 8'h00) ? DIV_ZERO_RES : a / b;
      OP_AND: return a & b;
      OP_OR:  return a | b;
      default: return a ^ b;
    endcase
  endfunction

  // Applies one item to the shadow state and returns the result it must produce.
  function automatic vm_result_t execute_item(logic m, addr_t la, logic [7:0] ld);
    vm_result_t res;
    logic [31:0] w;
    logic [31:0] w2;
    opcode_t     op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  moved [4];
    addr_t       npc;
    addr_t       tgt;
    addr_t       src;
    addr_t       dst;
    res.status   = ST_STEP;
    res.out_byte = 8'h00;
    if (m == MODE_LOAD) begin
      mem_store(la, ld);
      res.status = ST_LOAD;
    end else if (vm_halted) begin
      res.status = ST_HALT;
    end else begin
      w   = peek_word(vm_pc);
      op  = w[31:27];
      a   = w[23:16];
      b   = w[15:8];
      npc = addr_t'(vm_pc + 16'd4);
      if (op == OP_JMP) begin
        tgt = word_target(w);
        if (tgt == vm_pc) begin
          vm_halted = 1'b1;
          npc = vm_pc;
        end else begin
          npc = tgt;
        end
      end else if (op <= OP_XOR) begin
        mem_store(addr_t'(vm_pc + w[26:24]), alu_result(op, a, b));
      end else if (op == OP_OUT) begin
        res.status   = ST_OUT;
        res.out_byte = a;
      end else if (op == OP_BRZ) begin
        if (a == 8'h00) begin
          if (b == 8'h00) begin
            vm_halted = 1'b1;
            npc = vm_pc;
          end else begin
            npc = addr_t'(vm_pc + {b, 2'b00});
          end
        end
      end else if (op == OP_COPY) begin
        // All four source bytes are read before the first one is written.
        w2  = peek_word(addr_t'(vm_pc + 16'd4));
        src = word_target(w);
        dst = word_target(w2);
        for (int i = 0; i < 4; i++) moved[i] = vm_mem[addr_t'(src + i)];
        for (int i = 0; i < 4; i++) mem_store(addr_t'(dst + i), moved[i]);
        npc = addr_t'(vm_pc + 16'd8);
      end
      vm_pc = npc;
      if (vm_halted) res.status = ST_HALT;
    end
    res.next_pc = 16'(vm_pc);
    return res;
  endfunction

  // Operand bytes with a bias towards the extremes.
  function automatic logic [7:0] edgy_byte();
    int p;
    p = $urandom_range(99);
    if (p < 15) return 8'h00;
    if (p < 25) return 8'hff;
    if (p < 30) return 8'h80;
    if (p < 35) return 8'h01;
    return 8'($urandom);
  endfunction

  // Word-aligned address, mostly inside the working region, sometimes near either end or anywhere.
  function automatic addr_t pick_target();
    int p;
    p = $urandom_range(99);
    if (p < 70) return addr_t'(region_base + 4 * $urandom_range(63));
    if (p < 80) return addr_t'(16'hfffc - 4 * $urandom_range(3));
    if (p < 90) return addr_t'(4 * $urandom_range(15));
    return addr_t'({14'($urandom), 2'b00});
  endfunction

  function automatic bit will_halt(addr_t pc);
    logic [31:0] w;
    w = peek_word(pc);
    if (w[31:27] == OP_JMP) return word_target(w) == pc;
    if (w[31:27] == OP_BRZ) return w[23:8] == 16'h0000;
    return 1'b0;
  endfunction

  // A random instruction for address pc that never halts the machine.
  function automatic logic [31:0] random_instr(addr_t pc);
    int          p;
    logic [31:0] w;
    addr_t       t;
    p = $urandom_range(99);
    w = $urandom;
    if (p < 45) begin
      w[31:27] = opcode_t'($urandom_range(OP_ADD, OP_XOR));
      w[23:16] = edgy_byte();
      w[15:8]  = edgy_byte();
    end else if (p < 55) begin
      w[31:27] = OP_OUT;
      w[23:16] = edgy_byte();
    end else if (p < 65) begin
      t = pick_target();
      if (t == pc) t = addr_t'(pc + 16'd4);
      w = {OP_JMP, 13'($urandom), t[15:2]};
    end else if (p < 80) begin
      w[31:27] = OP_BRZ;
      w[23:16] = ($urandom_range(2) != 0) ? 8'h00 : edgy_byte();
      w[15:8]  = ($urandom_range(3) != 0) ? 8'($urandom_range(1, 16)) : edgy_byte();
      if (w[23:8] == 16'h0000) w[15:8] = 8'h01;
    end else if (p < 90) begin
      t = pick_target();
      w = {OP_COPY, 13'($urandom), t[15:2]};
    end else begin
      w[31:27] = opcode_t'($urandom_range(OP_OUT + 1, OP_BRZ - 1));
    end
    return w;
  endfunction

  // Offers one item, waits for it to be taken and records the result it must give.
  task automatic send_item(input logic m, input addr_t a, input logic [7:0] d,
                           input bit fixed = 1'b0, input vm_result_t fixed_res = '0);
    int         gap;
    vm_result_t got;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= m;
    in_if.load_addr <= a;
    in_if.load_data <= d;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    got = execute_item(m, a, d);
    awaited_results.push_back(fixed ? fixed_res : got);
    item_count++;
  endtask

  task automatic load_word(input addr_t a, input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_item(MODE_LOAD, addr_t'(a + i), w[31 - 8 * i -: 8]);
  endtask

  task automatic fill_undefined(input addr_t a);
    for (int i = 0; i < 4; i++) begin
      if (!vm_written[addr_t'(a + i)]) send_item(MODE_LOAD, addr_t'(a + i), 8'($urandom));
    end
  endtask

  // One step of a random program. Everything the step will read is loaded first,
  // and a halting instruction is replaced so that the halt is kept for the end.
  task automatic run_step();
    addr_t       pc;
    addr_t       t;
    logic [31:0] w;
    if ($urandom_range(99) < 8) send_item(MODE_LOAD, addr_t'($urandom), 8'($urandom));
    pc = vm_pc;
    if (!word_defined(pc) || will_halt(pc) || $urandom_range(99) < 20) begin
      load_word(pc, random_instr(pc));
    end
    w = peek_word(pc);
    if (w[31:27] == OP_COPY) begin
      t = pick_target();
      if (word_defined(addr_t'(pc + 16'd4))) begin
        // The following word already holds something; it names the destination.
      end else if (!vm_written[addr_t'(pc + 16'd4)] && !vm_written[addr_t'(pc + 16'd5)] &&
                   !vm_written[addr_t'(pc + 16'd6)] && !vm_written[addr_t'(pc + 16'd7)]) begin
        load_word(addr_t'(pc + 16'd4), {5'($urandom), 13'($urandom), t[15:2]});
      end else begin
        fill_undefined(addr_t'(pc + 16'd4));
      end
      fill_undefined(word_target(w));
    end
    send_item(MODE_STEP, addr_t'($urandom), 8'($urandom));
  endtask

  // Receiver side: ready is redrawn at every edge.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: every result is compared with the oldest awaited one.
  always @(posedge clk) begin
    vm_result_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: status %0d byte %02h pc %04h",
                   out_if.status, out_if.out_byte, out_if.next_pc);
        end
      end else begin
        want = awaited_results.pop_front();
        if (out_if.status !== want.status || out_if.out_byte !== want.out_byte ||
            out_if.next_pc !== want.next_pc) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d byte %02h pc %04h, got status %0d byte %02h pc %04h",
                     want.status, want.out_byte, want.next_pc,
                     out_if.status, out_if.out_byte, out_if.next_pc);
          end
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("byte_operand_vm_core test failed");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    addr_t       pc;
    logic [31:0] w;
    stim_row_t   r;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_LOAD;
    in_if.load_addr <= '0;
    in_if.load_data <= '0;
    vm_pc          = '0;
    vm_halted      = 1'b0;
    item_count     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    tx_idle_pct    = 29;
    rx_idle_pct    = 69;
    region_base    = addr_t'({14'($urandom), 2'b00});
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int i = 0; i < $size(directed_rows); i++) begin
      r = directed_rows[i];
      send_item(r.mode, r.addr, r.data, r.fixed,
                vm_result_t'({r.status, r.out_byte, r.next_pc}));
    end

    // Random programs, with the idling pattern changing over three phases.
    while (item_count < ITEM_TOTAL) begin
      if (item_count < ITEM_TOTAL / 3) begin
        tx_idle_pct = 29;
        rx_idle_pct = 69;
      end else if (item_count < 2 * ITEM_TOTAL / 3) begin
        tx_idle_pct = 69;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_step();
    end

    // Halt at the end, by a jump to itself or a branch by zero; the halt must stick
    // while loads still go through.
    pc = vm_pc;
    if ($urandom_range(1) == 0) begin
      w = {OP_JMP, 13'($urandom), pc[15:2]};
    end else begin
      w = {OP_BRZ, 3'($urandom), 16'h0000, 8'($urandom)};
    end
    load_word(pc, w);
    send_item(MODE_STEP, addr_t'($urandom), 8'($urandom));
    send_item(MODE_STEP, addr_t'($urandom), 8'($urandom));
    send_item(MODE_LOAD, addr_t'($urandom), 8'($urandom));
    send_item(MODE_STEP, addr_t'($urandom), 8'($urandom));
    in_if.valid <= 1'b0;

    // Drain the outstanding results, then allow for anything late.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("byte_operand_vm_core test passed");
    end else begin
      $display("byte_operand_vm_core test failed");
    end
    $finish;
  end

endmodule
